/* rtl/core/vtp_pkg.sv */
// Shared types and constants of the vertex transform and projection unit.
package vtp_pkg;

  localparam int unsigned NREG      = 8;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned XF_W      = 50;  // transformed component, signed
  localparam int unsigned MAG_W     = 51;  // magnitude of numerator / divisor
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned PROD_W    = MAG_W + QUO_W;
  localparam int unsigned XF_LAT    = 3;
  localparam int unsigned MD_LAT    = 3 + QUO_W;
  localparam int unsigned PIPE_LAT  = XF_LAT + 1 + MD_LAT + 1;

  localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;
  localparam logic signed [XF_W-1:0] FIX_ONE = XF_W'(65536);

  localparam logic [DATA_W-1:0] WEIGHT_RST [NREG] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef logic signed [XF_W-1:0] xf_t;
  typedef logic [MAG_W-1:0]       mag_t;

endpackage

/* rtl/core/vtp_intf.sv */
// Stream interfaces: vertex beats in, screen beats out.
interface vtp_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic signed [31:0] vertex_w;
  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_w, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, vertex_w, output ready);
endinterface

interface vtp_screen_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic [30:0]        screen_depth;
  logic               saturated;
  modport source (output valid, screen_x, screen_y, screen_depth, saturated, input ready);
  modport sink   (input valid, screen_x, screen_y, screen_depth, saturated, output ready);
endinterface

/* rtl/core/vertex_transform_project_unit.sv */
// Top level: vertex transform, perspective divide and viewport mapping.
// One vertex beat is taken every clock while the screen side does not stall; each beat
// passes three matrix stages, one setup stage, three multiply and overflow stages, the
// 32 one-bit restoring divide stages and the output clamp register. A stall on the screen
// side holds the whole pipeline. Weights are 64-bit APB registers at byte address 8*i
// and should only be written while the pipeline is empty.
module vertex_transform_project_unit import vtp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  vtp_vertex_if.sink        vertex,
  vtp_screen_if.source      screen
);

  logic [DATA_W-1:0]  weights [NREG];
  logic signed [31:0] vert [4];
  xf_t                xf [4];
  logic               en;
  logic [PIPE_LAT-1:0] valid_q;

  assign en           = !valid_q[PIPE_LAT-1] || screen.ready;
  assign vertex.ready = en;
  assign screen.valid = valid_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_LAT-2:0], vertex.valid};
    end
  end

  vtp_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .weights_o (weights)
  );

  assign vert[0] = vertex.vertex_x;
  assign vert[1] = vertex.vertex_y;
  assign vert[2] = vertex.vertex_z;
  assign vert[3] = vertex.vertex_w;

  vtp_transform u_xf (
    .clk_i, .en_i (en), .weights_i (weights), .vert_i (vert), .xf_o (xf)
  );

  // setup: zero w replaced by one, numerators, magnitudes and signs
  xf_t                     tw;
  logic signed [MAG_W-1:0] num [3];
  logic signed [MAG_W-1:0] dsg;
  mag_t                    mag_q [3];
  logic                    neg_q [3];
  mag_t                    den_q;

  always_comb begin
    tw     = (xf[3] == '0) ? FIX_ONE : xf[3];
    num[0] = MAG_W'(xf[0]) + MAG_W'(tw);
    num[1] = MAG_W'(tw) - MAG_W'(xf[1]);
    num[2] = MAG_W'(xf[2]) + MAG_W'(tw);
    dsg    = {tw, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= num[i][MAG_W-1] ? mag_t'(-num[i]) : mag_t'(num[i]);
        neg_q[i] <= num[i][MAG_W-1] ^ tw[XF_W-1];
      end
      den_q <= dsg[MAG_W-1] ? mag_t'(-dsg) : mag_t'(dsg);
    end
  end

  logic [QUO_W-1:0] kval [3];
  logic [QUO_W-1:0] quo  [3];
  logic             big  [3];
  logic             neg  [3];

  assign kval[0] = QUO_W'(SCREEN_WIDTH);
  assign kval[1] = QUO_W'(SCREEN_HEIGHT);
  assign kval[2] = DEPTH_MAX;

  for (genvar i = 0; i < 3; i++) begin : g_md
    vtp_muldiv u_md (
      .clk_i, .en_i (en), .mag_i (mag_q[i]), .den_i (den_q), .k_i (kval[i]),
      .neg_i (neg_q[i]), .quo_o (quo[i]), .big_o (big[i]), .neg_o (neg[i])
    );
  end

  // clamp to field ranges
  logic        sat [3];
  logic [15:0] sxy [2];
  logic [30:0] sdep;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sat[i] = big[i] || (!neg[i] && quo[i] > 32'd32767) || (neg[i] && quo[i] > 32'd32768);
      if (sat[i]) sxy[i] = neg[i] ? 16'h8000 : 16'h7FFF;
      else        sxy[i] = neg[i] ? 16'(-quo[i]) : quo[i][15:0];
    end
    sat[2] = big[2] || quo[2][31] || (neg[2] && quo[2] != '0);
    if (neg[2])       sdep = '0;
    else if (sat[2])  sdep = DEPTH_MAX[30:0];
    else              sdep = quo[2][30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      screen.screen_x     <= sxy[0];
      screen.screen_y     <= sxy[1];
      screen.screen_depth <= sdep;
      screen.saturated    <= sat[0] | sat[1] | sat[2];
    end
  end

endmodule

/* rtl/core/vtp_cfg_regs.sv */
// Matrix weight registers behind the APB-style port.
module vtp_cfg_regs import vtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [DATA_W-1:0] weights_o [NREG]
);

  logic [DATA_W-1:0] weights_q [NREG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= WEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      weights_q[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  assign prdata    = weights_q[paddr[ADDR_W-1:3]];
  assign pready    = 1'b1;
  assign weights_o = weights_q;

endmodule

/* rtl/core/vtp_transform.sv */
// Three-stage 4x4 matrix multiply: products, pair sums, row sums.
module vtp_transform import vtp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DATA_W-1:0]  weights_i [NREG],
  input  logic signed [31:0] vert_i [4],
  output xf_t                xf_o [4]
);

  logic signed [47:0]   prod_q [4][4];
  logic signed [48:0]   half_q [4][2];
  xf_t                  sum_q  [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [31:0] wt;
      logic signed [63:0] prod;
      assign wt   = weights_i[2*r + c/2][(c%2)*32 +: 32];
      assign prod = wt * vert_i[c];
      // arithmetic shift gives the floor of the Q32.32 product
      always_ff @(posedge clk_i) begin
        if (en_i) prod_q[r][c] <= prod[63:16];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        half_q[r][0] <= 49'(prod_q[r][0]) + 49'(prod_q[r][1]);
        half_q[r][1] <= 49'(prod_q[r][2]) + 49'(prod_q[r][3]);
        sum_q[r]     <= XF_W'(half_q[r][0]) + XF_W'(half_q[r][1]);
      end
    end
    assign xf_o[r] = sum_q[r];
  end

endmodule

/* rtl/core/vtp_muldiv.sv */
// Pipelined floor(mag * k / den): split multiply, overflow test, one quotient bit a stage.
module vtp_muldiv import vtp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  mag_t             mag_i,
  input  mag_t             den_i,
  input  logic [QUO_W-1:0] k_i,
  input  logic             neg_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             big_o,
  output logic             neg_o
);

  logic [63:0]       p0_q;
  logic [50:0]       p1_q;
  mag_t              den_a_q, den_b_q;
  logic              neg_a_q, neg_b_q;
  logic [PROD_W-1:0] prod_q;

  logic [PROD_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0]  quo_q [QUO_W+1];
  mag_t              den_q [QUO_W+1];
  logic              big_q [QUO_W+1];
  logic              neg_q [QUO_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q     <= 64'(mag_i[31:0]) * 64'(k_i);
      p1_q     <= 51'(mag_i[MAG_W-1:32]) * 51'(k_i);
      den_a_q  <= den_i;
      neg_a_q  <= neg_i;
      prod_q   <= PROD_W'(p0_q) + {p1_q, 32'b0};
      den_b_q  <= den_a_q;
      neg_b_q  <= neg_a_q;
      rem_q[0] <= prod_q;
      quo_q[0] <= '0;
      den_q[0] <= den_b_q;
      neg_q[0] <= neg_b_q;
      big_q[0] <= prod_q >= {den_b_q, 32'b0};
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int unsigned Bit = QUO_W - 1 - j;
    logic [PROD_W:0] trial;
    assign trial = {1'b0, rem_q[j]} - ((PROD_W+1)'(den_q[j]) << Bit);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= trial[PROD_W] ? rem_q[j] : trial[PROD_W-1:0];
        quo_q[j+1] <= quo_q[j] | ({{(QUO_W-1){1'b0}}, ~trial[PROD_W]} << Bit);
        den_q[j+1] <= den_q[j];
        big_q[j+1] <= big_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign big_o = big_q[QUO_W];
  assign neg_o = neg_q[QUO_W];

endmodule

/* tb/sv/vertex_transform_project_unit_tb.sv */
// Self-checking testbench of the vertex transform, perspective divide and viewport unit.
module vertex_transform_project_unit_tb import vtp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCR_W     = 640;
  localparam int unsigned SCR_H     = 480;
  localparam int unsigned IDLE_LIM  = 20000;
  localparam int unsigned SETTLE    = PIPE_LAT + 10;
  localparam logic [ADDR_W-1:0] A_XXY = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] A_WZW = ADDR_W'(56);

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [30:0]        depth;
    logic               sat;
  } screen_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  vtp_vertex_if vertex ();
  vtp_screen_if screen ();

  vertex_transform_project_unit #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vertex(vertex.sink), .screen(screen.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0]  weight_q [NREG];
  screen_beat_t screen_exp_q [$];
  int unsigned  n_fail, n_sent, n_got, n_sat, idle_cycles;
  bit           src_idle_en, snk_idle_en, hold_rx;

  initial begin
    vertex.valid = 1'b0;
    vertex.vertex_x = '0; vertex.vertex_y = '0; vertex.vertex_z = '0; vertex.vertex_w = '0;
    screen.ready = 1'b0;
  end

  function automatic longint floor16(longint p);
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  function automatic longint row_sum(int r, longint v[4]);
    logic [63:0] a, b;
    a = weight_q[2*r];
    b = weight_q[2*r+1];
    return floor16(longint'($signed(a[31:0])) * v[0]) + floor16(longint'($signed(a[63:32])) * v[1])
         + floor16(longint'($signed(b[31:0])) * v[2]) + floor16(longint'($signed(b[63:32])) * v[3]);
  endfunction

  // exact trunc(n*k/d) with the quotient capped, then clamped
  function automatic longint scale_clamp(longint n, longint d, longint k, longint lo,
                                         longint hi, ref bit sat);
    logic [127:0] num, q;
    logic [63:0]  an, ad;
    longint       v;
    bit           neg;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    num = 128'(an) * 128'(k);
    q = num / 128'(ad);
    if (q >= 128'h1_0000_0000_0000) q = 128'h1_0000_0000_0000;
    v = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    if (v < lo) begin sat = 1; return lo; end
    if (v > hi) begin sat = 1; return hi; end
    return v;
  endfunction

  function automatic screen_beat_t project_vertex(logic [31:0] x, y, z, w);
    longint v[4], tx, ty, tz, tw;
    bit sat;
    screen_beat_t r;
    v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z); v[3] = $signed(w);
    tx = row_sum(0, v); ty = row_sum(1, v); tz = row_sum(2, v); tw = row_sum(3, v);
    if (tw == 0) tw = 65536;
    sat = 0;
    r.sx = 16'(scale_clamp(tx + tw, 2*tw, SCR_W, -32768, 32767, sat));
    r.sy = 16'(scale_clamp(tw - ty, 2*tw, SCR_H, -32768, 32767, sat));
    r.depth = 31'(scale_clamp(tz + tw, 2*tw, 64'h7FFF_FFFF, 0, 64'h7FFF_FFFF, sat));
    r.sat = sat;
    return r;
  endfunction

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr / 8 < NREG) weight_q[addr/8] = data;
  endtask

  task automatic apb_check_read(logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; paddr <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== weight_q[addr/8])
      $error("weight readback: expected %h actual %h", weight_q[addr/8], prdata);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic send_vertex(logic [31:0] x, y, z, w);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      vertex.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    vertex.valid <= 1'b1;
    vertex.vertex_x <= x; vertex.vertex_y <= y; vertex.vertex_z <= z; vertex.vertex_w <= w;
    do @(posedge clk_i); while (!vertex.ready);
    screen_exp_q.push_back(project_vertex(x, y, z, w));
    n_sent++;
    @(negedge clk_i);
  endtask

  // called on a falling edge, so valid drops before the next rising edge
  task automatic drain();
    vertex.valid <= 1'b0;
    while (screen_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_fix();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      2: return {{14{$urandom_range(0,1) == 1}}, 18'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  task automatic test_directed();
    send_vertex(0, 0, 0, 0);                            // zero w used as one
    send_vertex(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000);
    send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'h8000_0000);
    send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 32'hFFFF_0000);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000, 32'h0002_0000);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    drain();
  endtask

  task automatic test_registers();
    for (int i = 0; i < NREG; i++) apb_check_read(ADDR_W'(8*i));
    // all-ones weights, extremes of every weight, then all-zero matrix so w is forced to one
    for (int i = 0; i < NREG; i++) apb_write(ADDR_W'(8*i), 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < NREG; i++) apb_check_read(ADDR_W'(8*i));
    for (int k = 0; k < 8; k++) send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    drain();
    for (int i = 0; i < NREG; i++) apb_write(ADDR_W'(8*i), 64'h8000_0000_7FFF_FFFF);
    for (int k = 0; k < 8; k++) send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    drain();
    for (int i = 0; i < NREG; i++) apb_write(ADDR_W'(8*i), 64'h0);
    for (int k = 0; k < 4; k++) send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    drain();
  endtask

  task automatic load_random_matrix(bit perspective);
    logic [63:0] wv;
    for (int i = 0; i < NREG; i++) begin
      wv = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0)
        wv = {32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536),
              32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536)};
      if (perspective && i == 7) wv = {32'h0, 32'($urandom_range(0, 2 * 65536))};
      apb_write(ADDR_W'(8*i), wv);
    end
    apb_check_read(A_XXY);
    apb_check_read(A_WZW);
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_random_matrix(p % 2 == 0);
      for (int k = 0; k < per_phase; k++)
        send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix());
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int k = 0; k < 120; k++) send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_fix());
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) screen.ready <= 1'b0;
    else if (hold_rx) begin
      screen.ready <= 1'b0;
      repeat (300) @(negedge clk_i);
      hold_rx = 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      screen.ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
      screen.ready <= 1'b1;
    end else screen.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    screen_beat_t e;
    if (rst_ni && screen.valid && screen.ready) begin
      if (screen_exp_q.size() == 0) begin
        $error("screen beat with nothing expected");
        n_fail++;
      end else begin
        e = screen_exp_q.pop_front();
        n_got++;
        if (e.sat) n_sat++;
        if (screen.screen_x !== e.sx) begin
          $error("screen_x: expected %0d actual %0d", e.sx, screen.screen_x); n_fail++;
        end
        if (screen.screen_y !== e.sy) begin
          $error("screen_y: expected %0d actual %0d", e.sy, screen.screen_y); n_fail++;
        end
        if (screen.screen_depth !== e.depth) begin
          $error("screen_depth: expected %0d actual %0d", e.depth, screen.screen_depth);
          n_fail++;
        end
        if (screen.saturated !== e.sat) begin
          $error("saturated: expected %0b actual %0b", e.sat, screen.saturated); n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vertex.valid && vertex.ready) || (screen.valid && screen.ready) || psel)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIM) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIM);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NREG; i++) weight_q[i] = WEIGHT_RST[i];
    src_idle_en = 1'b1; snk_idle_en = 1'b1; hold_rx = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_registers();
    test_backpressure();
    test_random(10, 120);
    src_idle_en = 1'b0; snk_idle_en = 1'b0;
    test_random(2, 150);
    $display("Covered %0d vertices over random and extreme matrices, %0d saturated beats.",
             n_sent, n_sat);
    if (n_fail == 0 && screen_exp_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* vertex_transform_project_unit.f */
rtl/core/vtp_pkg.sv
rtl/core/vtp_intf.sv
rtl/core/vtp_cfg_regs.sv
rtl/core/vtp_transform.sv
rtl/core/vtp_muldiv.sv
rtl/core/vertex_transform_project_unit.sv
tb/sv/vertex_transform_project_unit_tb.sv
